FILE: hdl/linked_stack_arena_allocator_top_macros.svh
// Assertion helpers for the linked stack arena allocator.
// The macros expect signals named clock and reset in the scope where they are used.
`ifndef LINKED_STACK_ARENA_ALLOCATOR_TOP_MACROS_SVH
`define LINKED_STACK_ARENA_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define LSAA_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsaa assertion failed");

// Next-cycle implication, checked outside reset
`define LSAA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsaa assertion failed");

`else

`define LSAA_ASSERT_IMPLY(name, ante, cons)
`define LSAA_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: hdl/lsaa_pkg.sv
`default_nettype none

package lsaa_pkg;

   // Arena geometry
   localparam int ARENA_WORDS = 512;
   localparam int WORD_BYTES  = 8;
   localparam int WORD_BITS   = 8 * WORD_BYTES;
   localparam int ADDR_W      = $clog2(ARENA_WORDS);
   localparam int BYTE_LSB    = $clog2(WORD_BYTES);
   localparam int HDR_BYTES   = 2 * WORD_BYTES;

   // Field widths
   localparam int OP_W     = 3;
   localparam int SIZE_W   = 16;
   localparam int WOFF_W   = 9;
   localparam int DATA_W   = 64;
   localparam int CAP_W    = 13;
   localparam int OFFS_W   = 12;
   localparam int IDX_W    = CAP_W - BYTE_LSB;
   localparam int ALIGN_W  = SIZE_W + 1;
   localparam int ENTRY_W  = SIZE_W + 2;
   localparam int BYTEA_W  = CAP_W + 1;

   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(ARENA_WORDS * WORD_BYTES);
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);
   localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(ARENA_WORDS);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_CLEAR = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_RESP
   } fsm_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;     // first step of an accepted request
      logic finish;    // second step: second header word, link or read data
      logic load_rsp;  // load the response register
   } cmd_type;

endpackage

`default_nettype wire

FILE: hdl/linked_stack_arena_allocator_top.sv
// Linked stack arena allocator.
// Requests enter on req_valid/req_stall with an operation (push, pop, clear, write
// word, read word), a push size, a word offset and write data. Each request gives one
// response on rsp_valid/rsp_stall: status, payload offset of a new entry, head state,
// used and available bytes, and the word returned by a read.
// The capacity register is written through csr_valid/csr_ready, always ready; write it
// only while no request is in flight.
// An accepted request passes through the execute and response states, where its
// response is loaded. Each request uses the single arena memory port in a start and a
// finish step (two header words on push, link read then update on pop), and no new
// request is taken before the last reaches its response state and the response side keeps up.
// Reset clears the used count, head link and response valid and sets the capacity to
// 4096 bytes; arena contents are undefined until written.
// When rsp_stall holds a response, the next request finishes its work and then waits
// for the response register; req_stall stays high until it can be loaded.
`default_nettype none

`include "linked_stack_arena_allocator_top_macros.svh"

module linked_stack_arena_allocator_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [lsaa_pkg::OP_W-1:0]    req_operation,
   input  wire logic [lsaa_pkg::SIZE_W-1:0]  req_request_size,
   input  wire logic [lsaa_pkg::WOFF_W-1:0]  req_word_offset,
   input  wire logic [lsaa_pkg::DATA_W-1:0]  req_write_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [lsaa_pkg::OFFS_W-1:0]       rsp_payload_offset,
   output logic                              rsp_head_valid,
   output logic [lsaa_pkg::OFFS_W-1:0]       rsp_head_offset,
   output logic [lsaa_pkg::CAP_W-1:0]        rsp_used_bytes,
   output logic [lsaa_pkg::CAP_W-1:0]        rsp_available_bytes,
   output logic [lsaa_pkg::DATA_W-1:0]       rsp_read_word,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [lsaa_pkg::CAP_W-1:0]   csr_capacity_bytes
);
   import lsaa_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   // Sequencer
   lsaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Arena, pointers and response register
   lsaa_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_operation       (req_operation),
      .req_request_size    (req_request_size),
      .req_word_offset     (req_word_offset),
      .req_write_data      (req_write_data),
      .csr_write           (csr_valid && csr_ready),
      .csr_capacity_bytes  (csr_capacity_bytes),
      .rsp_status          (rsp_status),
      .rsp_payload_offset  (rsp_payload_offset),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_offset     (rsp_head_offset),
      .rsp_used_bytes      (rsp_used_bytes),
      .rsp_available_bytes (rsp_available_bytes),
      .rsp_read_word       (rsp_read_word)
   );

   // Checks
   // a response only appears after the sequencer loads it
   `LSAA_ASSERT_IMPLY(a_rsp_from_load, $rose(rsp_valid), $past(cmd.load_rsp))
   // an accepted request keeps req_stall high while it executes
   `LSAA_ASSERT_NEXT(a_two_cycle_req, req_valid && !req_stall, req_stall)
   // only a successful request reports a payload offset
   `LSAA_ASSERT_IMPLY(a_payload_ok, rsp_valid && rsp_status != ST_OK,
                      rsp_payload_offset == '0)
   // used plus available never exceeds the arena
   `LSAA_ASSERT_IMPLY(a_occupancy, rsp_valid,
                      (BYTEA_W'(rsp_used_bytes) + BYTEA_W'(rsp_available_bytes))
                      <= BYTEA_W'(CAP_MAX))

endmodule

`default_nettype wire

FILE: hdl/lsaa_ctrl.sv
`default_nettype none

module lsaa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lsaa_pkg::cmd_type     cmd
);
   import lsaa_pkg::*;

   fsm_type state_ff;
   fsm_type state_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    out_free;
   logic    accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            state_in = FSM_RESP;
         end
         FSM_RESP: begin
            if (out_free) state_in = req_valid ? FSM_EXEC : FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Outputs and commands
   always_comb begin
      req_stall    = 1'b1;
      cmd          = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
         end
         FSM_EXEC: begin
            cmd.finish = 1'b1;
         end
         FSM_RESP: begin
            req_stall    = !out_free;
            cmd.load_rsp = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      accept    = req_valid && !req_stall;
      cmd.start = accept;
   end

   // Response valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hdl/lsaa_dp.sv
`default_nettype none

module lsaa_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lsaa_pkg::cmd_type            cmd,
   input  wire logic [lsaa_pkg::OP_W-1:0]    req_operation,
   input  wire logic [lsaa_pkg::SIZE_W-1:0]  req_request_size,
   input  wire logic [lsaa_pkg::WOFF_W-1:0]  req_word_offset,
   input  wire logic [lsaa_pkg::DATA_W-1:0]  req_write_data,
   input  wire logic                         csr_write,
   input  wire logic [lsaa_pkg::CAP_W-1:0]   csr_capacity_bytes,
   output logic [1:0]                        rsp_status,
   output logic [lsaa_pkg::OFFS_W-1:0]       rsp_payload_offset,
   output logic                              rsp_head_valid,
   output logic [lsaa_pkg::OFFS_W-1:0]       rsp_head_offset,
   output logic [lsaa_pkg::CAP_W-1:0]        rsp_used_bytes,
   output logic [lsaa_pkg::CAP_W-1:0]        rsp_available_bytes,
   output logic [lsaa_pkg::DATA_W-1:0]       rsp_read_word
);
   import lsaa_pkg::*;

   // Arena memory, single port, registered read
   logic [WORD_BITS-1:0] arena [ARENA_WORDS];
   logic                 mem_we;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_addr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [WORD_BITS-1:0] mem_rdata_ff;

   // Allocator state
   logic [CAP_W-1:0]  capacity_ff, used_ff, used_in, head_ff, head_in;

   // Per-request staging
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CAP_W-1:0]  node_ff, node_in;
   logic [CAP_W-1:0]  entry_ff, entry_in;
   logic              go_ff, go_in;
   logic              oob_ff, oob_in;
   status_type        status_ff, status_in;
   logic [OFFS_W-1:0] payload_ff, payload_in;
   logic [DATA_W-1:0] rword_ff, rword_in;

   // Response register
   logic [1:0]        rsp_status_ff;
   logic [OFFS_W-1:0] rsp_payload_ff, rsp_head_off_ff;
   logic              rsp_head_valid_ff;
   logic [CAP_W-1:0]  rsp_used_ff, rsp_avail_ff;
   logic [DATA_W-1:0] rsp_rword_ff;

   // Capacity view and push sizing
   logic [CAP_W-1:0]   cap;
   logic               used_ok;
   logic [CAP_W-1:0]   room;
   logic [ALIGN_W-1:0] aligned;
   logic [ENTRY_W-1:0] entry;
   logic               fits;
   logic [IDX_W-1:0]   push_idx, hdr1_idx;
   logic [CAP_W-1:0]   pop_node;
   logic [IDX_W-1:0]   pop_idx;
   logic [BYTEA_W-1:0] word_end;
   logic               word_ok;
   logic [CAP_W-1:0]   avail_rem, avail_r;

   assign cap      = (capacity_ff > CAP_MAX) ? CAP_MAX : capacity_ff;
   assign used_ok  = used_ff <= cap;
   assign room     = cap - used_ff;
   assign aligned  = (ALIGN_W'(req_request_size) + ALIGN_W'(WORD_BYTES - 1))
                     & ~ALIGN_W'(WORD_BYTES - 1);
   assign entry    = ENTRY_W'(aligned) + ENTRY_W'(HDR_BYTES);
   assign fits     = used_ok && (entry <= ENTRY_W'(room));
   assign push_idx = used_ff[CAP_W-1:BYTE_LSB];
   assign hdr1_idx = idx_ff + IDX_W'(1);
   assign pop_node = head_ff - CAP_W'(1);
   assign pop_idx  = pop_node[CAP_W-1:BYTE_LSB];
   // End byte of the addressed word must lie within the capacity
   assign word_end = BYTEA_W'({req_word_offset, BYTE_LSB'(0)}) + BYTEA_W'(WORD_BYTES);
   assign word_ok  = (WOFF_W'(req_word_offset) < WOFF_W'(ARENA_WORDS - 1)
                      || req_word_offset == WOFF_W'(ARENA_WORDS - 1))
                     && (word_end <= BYTEA_W'(cap));

   // Step logic: memory port and next values
   always_comb begin
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = '0;
      mem_wdata  = '0;
      used_in    = used_ff;
      head_in    = head_ff;
      op_in      = op_ff;
      size_in    = size_ff;
      idx_in     = idx_ff;
      node_in    = node_ff;
      entry_in   = entry_ff;
      go_in      = go_ff;
      oob_in     = oob_ff;
      status_in  = status_ff;
      payload_in = payload_ff;
      rword_in   = rword_ff;

      if (cmd.start) begin
         op_in      = req_operation;
         size_in    = req_request_size;
         go_in      = 1'b0;
         oob_in     = 1'b0;
         status_in  = ST_OK;
         payload_in = '0;
         rword_in   = '0;
         unique case (op_type'(req_operation))
            OP_PUSH: begin
               idx_in   = push_idx;
               entry_in = entry[CAP_W-1:0];
               go_in    = fits;
               if (!fits) begin
                  status_in = ST_NO_ROOM;
               end else if (push_idx < IDX_LIMIT) begin
                  // header word 0: previous head link
                  mem_we    = 1'b1;
                  mem_addr  = push_idx[ADDR_W-1:0];
                  mem_wdata = WORD_BITS'(head_ff);
               end
            end
            OP_POP: begin
               node_in = pop_node;
               oob_in  = !(pop_idx < IDX_LIMIT);
               if (!used_ok || head_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  go_in    = 1'b1;
                  mem_re   = pop_idx < IDX_LIMIT;
                  mem_addr = pop_idx[ADDR_W-1:0];
               end
            end
            OP_CLEAR: begin
               used_in = '0;
               head_in = '0;
            end
            OP_WRITE: begin
               if (!word_ok) begin
                  status_in = ST_RANGE;
               end else begin
                  mem_we    = 1'b1;
                  mem_addr  = ADDR_W'(req_word_offset);
                  mem_wdata = WORD_BITS'(req_write_data);
               end
            end
            OP_READ: begin
               if (!word_ok) begin
                  status_in = ST_RANGE;
               end else begin
                  go_in    = 1'b1;
                  mem_re   = 1'b1;
                  mem_addr = ADDR_W'(req_word_offset);
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end

      if (cmd.finish && go_ff) begin
         unique case (op_type'(op_ff))
            OP_PUSH: begin
               // header word 1: requested size
               if (hdr1_idx < IDX_LIMIT) begin
                  mem_we    = 1'b1;
                  mem_addr  = hdr1_idx[ADDR_W-1:0];
                  mem_wdata = WORD_BITS'(size_ff);
               end
               head_in    = used_ff + CAP_W'(1);
               used_in    = used_ff + entry_ff;
               payload_in = OFFS_W'(used_ff + CAP_W'(HDR_BYTES));
            end
            OP_POP: begin
               head_in = oob_ff ? '0 : mem_rdata_ff[CAP_W-1:0];
               used_in = node_ff;
            end
            OP_READ: begin
               rword_in = DATA_W'(mem_rdata_ff);
            end
            default: begin
               rword_in = rword_ff;
            end
         endcase
      end
   end

   // Arena port
   always_ff @(posedge clock) begin
      if (mem_we) arena[mem_addr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= arena[mem_addr];
   end

   // Control state: capacity register, used count, head link
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         used_ff     <= '0;
         head_ff     <= '0;
      end else begin
         if (csr_write) capacity_ff <= csr_capacity_bytes;
         used_ff <= used_in;
         head_ff <= head_in;
      end
   end

   // Staging registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      size_ff    <= size_in;
      idx_ff     <= idx_in;
      node_ff    <= node_in;
      entry_ff   <= entry_in;
      go_ff      <= go_in;
      oob_ff     <= oob_in;
      status_ff  <= status_in;
      payload_ff <= payload_in;
      rword_ff   <= rword_in;
   end

   // Occupancy summary of the current state
   assign avail_rem = room - CAP_W'(HDR_BYTES);
   assign avail_r   = {avail_rem[CAP_W-1:BYTE_LSB], BYTE_LSB'(0)};

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff     <= status_ff;
         rsp_payload_ff    <= payload_ff;
         rsp_head_valid_ff <= head_ff != '0;
         rsp_head_off_ff   <= (head_ff != '0) ? OFFS_W'(head_ff - CAP_W'(1)) : '0;
         rsp_used_ff       <= used_ok ? used_ff : '0;
         rsp_avail_ff      <= (used_ok && room >= CAP_W'(HDR_BYTES)) ? avail_r : '0;
         rsp_rword_ff      <= rword_ff;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_payload_offset  = rsp_payload_ff;
   assign rsp_head_valid      = rsp_head_valid_ff;
   assign rsp_head_offset     = rsp_head_off_ff;
   assign rsp_used_bytes      = rsp_used_ff;
   assign rsp_available_bytes = rsp_avail_ff;
   assign rsp_read_word       = rsp_rword_ff;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
   import lsaa_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int RSP_LATENCY     = 2;
   localparam int SETTLE_CYCLES   = RSP_LATENCY + 2;
   localparam int TIMEOUT_TIME    = 2_000_000;
   localparam int MAX_REPORTS     = 10;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 138;
   localparam int DIRECTED_ROWS   = 29;

   localparam int unsigned LINK_MASK     = 32'h1FFF;
   localparam int unsigned CAP_FIELD_MAX = 8191;

   // operation codes the block treats as no-ops
   localparam logic [OP_W-1:0] OP_NOP_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_NOP_LAST  = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SIZE_W-1:0] size;
      logic [WOFF_W-1:0] woff;
      logic [DATA_W-1:0] data;
   } alloc_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [OFFS_W-1:0] payload_offset;
      logic              head_valid;
      logic [OFFS_W-1:0] head_offset;
      logic [CAP_W-1:0]  used_bytes;
      logic [CAP_W-1:0]  available_bytes;
      logic [DATA_W-1:0] read_word;
   } alloc_rsp_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [CAP_W-1:0] cap;
      alloc_req_type    req;
      logic             typed;
      alloc_rsp_type    want;
   } dir_row_type;

   localparam alloc_req_type NO_REQ   = '0;
   localparam alloc_rsp_type NO_CHECK = '0;

   // DUT signals
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = '0;
   logic [SIZE_W-1:0]   req_request_size = '0;
   logic [WOFF_W-1:0]   req_word_offset = '0;
   logic [DATA_W-1:0]   req_write_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [OFFS_W-1:0]   rsp_payload_offset;
   logic                rsp_head_valid;
   logic [OFFS_W-1:0]   rsp_head_offset;
   logic [CAP_W-1:0]    rsp_used_bytes;
   logic [CAP_W-1:0]    rsp_available_bytes;
   logic [DATA_W-1:0]   rsp_read_word;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_capacity_bytes = '0;

   // allocator mirror
   logic [DATA_W-1:0]   arena_mirror [ARENA_WORDS];
   bit                  arena_written [ARENA_WORDS];
   int unsigned         mirror_used = 0;
   int unsigned         mirror_head_link = 0;
   int unsigned         mirror_capacity = CAP_RESET;

   alloc_rsp_type       pending_responses [$];
   int                  error_count = 0;
   int                  sender_idle_pct = 0;
   int                  recv_stall_pct = 0;

   // directed requests; typed rows carry a hand-derived response
   dir_row_type directed_table [DIRECTED_ROWS] = '{
      // empty stack, then two entries and one that cannot fit
      '{ROW_REQ, 0, '{OP_POP, 0, 0, 0}, 1, '{ST_EMPTY, 0, 0, 0, 0, 4080, 0}},
      '{ROW_REQ, 0, '{OP_PUSH, 0, 0, 0}, 1, '{ST_OK, 16, 1, 0, 16, 4064, 0}},
      '{ROW_REQ, 0, '{OP_PUSH, 1, 0, 0}, 1, '{ST_OK, 32, 1, 16, 40, 4040, 0}},
      '{ROW_REQ, 0, '{OP_PUSH, 16'hFFFF, 0, 0}, 1,
        '{ST_NO_ROOM, 0, 1, 16, 40, 4040, 0}},
      '{ROW_REQ, 0, '{OP_READ, 0, 2, 0}, 0, NO_CHECK},
      // last arena word, all ones
      '{ROW_REQ, 0, '{OP_WRITE, 0, 511, '1}, 1, '{ST_OK, 0, 1, 16, 40, 4040, 0}},
      '{ROW_REQ, 0, '{OP_READ, 0, 511, 0}, 1, '{ST_OK, 0, 1, 16, 40, 4040, '1}},
      '{ROW_REQ, 0, '{OP_NOP_LAST, 16'hFFFF, 9'h1FF, '1}, 1,
        '{ST_OK, 0, 1, 16, 40, 4040, 0}},
      // corrupted link leaves an unaligned used count
      '{ROW_REQ, 0, '{OP_POP, 0, 0, 0}, 0, NO_CHECK},
      '{ROW_REQ, 0, '{OP_WRITE, 0, 0, 64'hFFFF_FFFF_FFFF_E015}, 0, NO_CHECK},
      '{ROW_REQ, 0, '{OP_POP, 0, 0, 0}, 0, NO_CHECK},
      '{ROW_REQ, 0, '{OP_POP, 0, 0, 0}, 0, NO_CHECK},
      '{ROW_REQ, 0, '{OP_PUSH, 9, 0, 0}, 0, NO_CHECK},
      '{ROW_REQ, 0, '{OP_CLEAR, 0, 0, 0}, 1, '{ST_OK, 0, 0, 0, 0, 4080, 0}},
      // exact fill
      '{ROW_REQ, 0, '{OP_PUSH, 4080, 0, 0}, 1, '{ST_OK, 16, 1, 0, 4096, 0, 0}},
      '{ROW_REQ, 0, '{OP_PUSH, 0, 0, 0}, 1, '{ST_NO_ROOM, 0, 1, 0, 4096, 0, 0}},
      // capacity lowered under the used count
      '{ROW_CSR, 100, NO_REQ, 0, NO_CHECK},
      '{ROW_REQ, 0, '{OP_PUSH, 0, 0, 0}, 1, '{ST_NO_ROOM, 0, 1, 0, 0, 0, 0}},
      '{ROW_REQ, 0, '{OP_POP, 0, 0, 0}, 1, '{ST_EMPTY, 0, 1, 0, 0, 0, 0}},
      '{ROW_REQ, 0, '{OP_READ, 0, 12, 0}, 1, '{ST_RANGE, 0, 1, 0, 0, 0, 0}},
      '{ROW_REQ, 0, '{OP_CLEAR, 0, 0, 0}, 1, '{ST_OK, 0, 0, 0, 0, 80, 0}},
      '{ROW_REQ, 0, '{OP_PUSH, 81, 0, 0}, 1, '{ST_NO_ROOM, 0, 0, 0, 0, 80, 0}},
      '{ROW_REQ, 0, '{OP_PUSH, 80, 0, 0}, 1, '{ST_OK, 16, 1, 0, 96, 0, 0}},
      // zero capacity
      '{ROW_CSR, 0, NO_REQ, 0, NO_CHECK},
      '{ROW_REQ, 0, '{OP_WRITE, 0, 0, 0}, 1, '{ST_RANGE, 0, 1, 0, 0, 0, 0}},
      '{ROW_REQ, 0, '{OP_CLEAR, 0, 0, 0}, 1, '{ST_OK, 0, 0, 0, 0, 0, 0}},
      '{ROW_REQ, 0, '{OP_PUSH, 0, 0, 0}, 1, '{ST_NO_ROOM, 0, 0, 0, 0, 0, 0}},
      // register maximum, clamped to the arena size
      '{ROW_CSR, 13'h1FFF, NO_REQ, 0, NO_CHECK},
      '{ROW_REQ, 0, '{OP_READ, 0, 1, 0}, 0, NO_CHECK}
   };

   int unsigned phase_caps [PHASES] = '{4096, 8191, 1024, 4095, 200, 0, 3000, 4096};

   linked_stack_arena_allocator_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_request_size    (req_request_size),
      .req_word_offset     (req_word_offset),
      .req_write_data      (req_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_payload_offset  (rsp_payload_offset),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_offset     (rsp_head_offset),
      .rsp_used_bytes      (rsp_used_bytes),
      .rsp_available_bytes (rsp_available_bytes),
      .rsp_read_word       (rsp_read_word),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capacity_bytes  (csr_capacity_bytes)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // capacity in effect: register clamped to the arena
   function automatic int unsigned mirror_cap();
      return (mirror_capacity < CAP_MAX) ? mirror_capacity : int'(CAP_MAX);
   endfunction

   function automatic void store_word(int unsigned idx, logic [DATA_W-1:0] value);
      if (idx < ARENA_WORDS) begin
         arena_mirror[idx] = value;
         arena_written[idx] = 1'b1;
      end
   endfunction

   function automatic logic [DATA_W-1:0] fetch_word(int unsigned idx);
      return (idx < ARENA_WORDS) ? arena_mirror[idx] : '0;
   endfunction

   // Applies one request to the mirror and returns the response it should give
   function automatic alloc_rsp_type predict_alloc_response(alloc_req_type r);
      int unsigned       cap, aligned, entry, node, left;
      bit                in_bounds;
      logic [DATA_W-1:0] link_word;
      alloc_rsp_type     p;
      p = '0;
      cap = mirror_cap();
      in_bounds = (mirror_used <= cap);
      case (r.op) inside
         OP_PUSH: begin
            aligned = r.size;
            aligned = (aligned + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
            entry = HDR_BYTES + aligned;
            if (!in_bounds || entry > cap - mirror_used) begin
               p.status = ST_NO_ROOM;
            end else begin
               node = mirror_used;
               store_word(node / WORD_BYTES, DATA_W'(mirror_head_link));
               store_word(node / WORD_BYTES + 1, DATA_W'(r.size));
               mirror_head_link = (node + 1) & LINK_MASK;
               mirror_used = (node + entry) & LINK_MASK;
               p.payload_offset = OFFS_W'(node + HDR_BYTES);
            end
         end
         OP_POP: begin
            if (!in_bounds || mirror_head_link == 0) begin
               p.status = ST_EMPTY;
            end else begin
               node = mirror_head_link - 1;
               link_word = fetch_word(node / WORD_BYTES);
               mirror_head_link = link_word[CAP_W-1:0];
               mirror_used = node & LINK_MASK;
            end
         end
         OP_CLEAR: begin
            mirror_used = 0;
            mirror_head_link = 0;
         end
         OP_WRITE, OP_READ: begin
            if (r.woff * WORD_BYTES + WORD_BYTES > cap) begin
               p.status = ST_RANGE;
            end else if (r.op == OP_WRITE) begin
               store_word(r.woff, r.data);
            end else begin
               p.read_word = fetch_word(r.woff);
            end
         end
         default: ;
      endcase

      // head and space summary after the update
      in_bounds = (mirror_used <= cap);
      p.head_valid = (mirror_head_link != 0);
      p.head_offset = p.head_valid ? OFFS_W'(mirror_head_link - 1) : '0;
      if (in_bounds) begin
         p.used_bytes = CAP_W'(mirror_used);
         left = cap - mirror_used;
         if (left >= HDR_BYTES)
            p.available_bytes = CAP_W'((left - HDR_BYTES) / WORD_BYTES * WORD_BYTES);
      end
      return p;
   endfunction

   function automatic string format_response(alloc_rsp_type x);
      return $sformatf({"status=%0d payload=%0d head_valid=%0d head=%0d",
                        " used=%0d avail=%0d word=%h"},
                       x.status, x.payload_offset, x.head_valid, x.head_offset,
                       x.used_bytes, x.available_bytes, x.read_word);
   endfunction

   task automatic note_failure(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic select_idling(int mode);
      case (mode % 4)
         0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin sender_idle_pct = 76; recv_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  recv_stall_pct = 76; end
         default: begin sender_idle_pct = 30; recv_stall_pct = 30; end
      endcase
   endtask

   // Drives one request, waits for acceptance, queues its response, then may idle for a random gap
   task automatic send_request(alloc_req_type r, bit typed, alloc_rsp_type typed_rsp);
      alloc_rsp_type predicted;
      int            gap;
      req_operation    <= r.op;
      req_request_size <= r.size;
      req_word_offset  <= r.woff;
      req_write_data   <= r.data;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = predict_alloc_response(r);
      pending_responses.push_back(typed ? typed_rsp : predicted);
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Capacity write, only once every pending response has drained
   task automatic write_capacity(int unsigned value);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_capacity_bytes <= CAP_W'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mirror_capacity = value & LINK_MASK;
   endtask

   // Response side: random stall and in-order check
   always @(posedge clock) begin : response_check
      alloc_rsp_type got, want;
      string         bad;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            got.status          = rsp_status;
            got.payload_offset  = rsp_payload_offset;
            got.head_valid      = rsp_head_valid;
            got.head_offset     = rsp_head_offset;
            got.used_bytes      = rsp_used_bytes;
            got.available_bytes = rsp_available_bytes;
            got.read_word       = rsp_read_word;
            if (pending_responses.size() == 0) begin
               note_failure({"response with no request pending: ", format_response(got)});
            end else begin
               want = pending_responses.pop_front();
               bad = "";
               if (got.status !== want.status) bad = {bad, " status"};
               if (got.payload_offset !== want.payload_offset) bad = {bad, " payload_offset"};
               if (got.head_valid !== want.head_valid) bad = {bad, " head_valid"};
               if (got.head_offset !== want.head_offset) bad = {bad, " head_offset"};
               if (got.used_bytes !== want.used_bytes) bad = {bad, " used_bytes"};
               if (got.available_bytes !== want.available_bytes)
                  bad = {bad, " available_bytes"};
               if (got.read_word !== want.read_word) bad = {bad, " read_word"};
               if (bad != "")
                  note_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                                         bad, format_response(want), format_response(got)));
            end
         end
      end
   end

   initial begin : stimulus
      alloc_req_type r;
      int            pick, near;
      int unsigned   node, cap_words;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      select_idling(3);
      foreach (directed_table[i]) begin
         if (directed_table[i].kind == ROW_CSR)
            write_capacity(directed_table[i].cap);
         else
            send_request(directed_table[i].req, directed_table[i].typed,
                         directed_table[i].want);
      end

      // random phases, each with its own capacity and idling pattern
      phase_caps[5] = $urandom_range(0, CAP_FIELD_MAX);
      for (int ph = 0; ph < PHASES; ph++) begin
         select_idling(ph);
         write_capacity(phase_caps[ph]);
         repeat (ITEMS_PER_PHASE) begin
            r.size = SIZE_W'($urandom_range(0, 65535));
            r.woff = WOFF_W'($urandom_range(0, ARENA_WORDS - 1));
            r.data = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               // mostly small entries, a few huge ones
               r.op = OP_PUSH;
               pick = $urandom_range(0, 99);
               if (pick < 70) r.size = SIZE_W'($urandom_range(0, 64));
               else if (pick < 90) r.size = SIZE_W'($urandom_range(0, 600));
               else if (pick < 97) r.size = SIZE_W'($urandom_range(0, 4096));
            end else if (pick < 50) begin
               // a pop must not follow a link into never-written memory
               r.op = OP_POP;
               node = mirror_head_link - 1;
               if (mirror_used <= mirror_cap() && mirror_head_link != 0 &&
                   node / WORD_BYTES < ARENA_WORDS && !arena_written[node / WORD_BYTES])
                  r.op = OP_CLEAR;
            end else if (pick < 90) begin
               r.op = (pick < 70) ? OP_WRITE : OP_READ;
               cap_words = mirror_cap() / WORD_BYTES;
               pick = $urandom_range(0, 99);
               if (mirror_head_link != 0 && pick < 50) begin
                  // around the top entry; writes rarely touch its link word
                  near = (r.op == OP_WRITE && $urandom_range(0, 19) != 0) ? 1 : 0;
                  r.woff = WOFF_W'((mirror_head_link - 1) / WORD_BYTES +
                                   $urandom_range(near, 3));
               end else if (pick < 80 && cap_words > 0) begin
                  r.woff = WOFF_W'($urandom_range(0, cap_words - 1));
               end
               // an in-range read of a never-written word turns into a write
               if (r.op == OP_READ && r.woff * WORD_BYTES + WORD_BYTES <= mirror_cap() &&
                   !arena_written[r.woff])
                  r.op = OP_WRITE;
            end else if (pick < 95) begin
               r.op = OP_CLEAR;
            end else begin
               r.op = OP_W'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
            end
            send_request(r, 1'b0, NO_CHECK);
         end
      end

      // drain and finish
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (pending_responses.size() != 0)
         note_failure($sformatf("%0d responses never arrived", pending_responses.size()));
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_TIME);
      $display("ERROR: timeout waiting for the block");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
